/* rtl/core/vfh_pkg.sv */
package vfh_pkg;

	localparam int SIDE_DEF       = 64;
	localparam int COUNT_BITS_DEF = 32;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_CNT_W   = 32;
	localparam int ECHO_W      = 6;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BINS_PER_UNIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE     = 1'd1;

	typedef struct packed {
		logic              vld;
		logic [1:0]        op;
		logic              hit;
		logic              last;
		logic [ECHO_W-1:0] col;
		logic [ECHO_W-1:0] row;
	} vfh_item_t;

endpackage

/* rtl/core/vector_field_2d_histogram_core.sv */
// Two-dimensional histogram of a flow-vector stream.
// Requests arrive on the s_* stream: opcode add (vector in Q8.8), read bin,
// or read-and-clear bin; s_tlast is the frame marker and is echoed on m_tlast.
// Every request yields exactly one response on the m_* stream carrying the
// bin coordinates and the bin count (after the increment for an add, before
// the clear for a read). Counters saturate at all ones.
// Configuration: cfg_we/cfg_index/cfg_data write bins_per_unit (index 0) and
// grid_side (index 1); write only while no request is in flight.
// Each request walks a 5-stage path (capture, multiply, round, clamp/address,
// RAM read-modify-write) and the next one is taken in the cycle the previous
// one writes back, so only one request is in flight and RAM read-after-write
// hazards cannot occur. The response is registered when the request writes back.
// Reset: the bin RAM is swept to zero, one entry per cycle, over all SIDE*SIDE
// entries (4096 by default); s_tready stays low during the sweep.
// Back-pressure: one output register; a request finished while the
// response still waits holds in the last stage until m_tready.
module vector_field_2d_histogram_core
	import vfh_pkg::*;
#(
	parameter int SIDE       = SIDE_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // opcode, vec_u, vec_v, read_col, read_row
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // bin_col, bin_row, bin_count
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int CW    = $clog2(SIDE);
	localparam int DEPTH = SIDE * SIDE;
	localparam int AW    = $clog2(DEPTH);

	logic [CFG_W-1:0]      bpu_q, gside_q;
	logic                  clr_q;
	logic [AW-1:0]         clr_addr_q;

	vfh_item_t             item;
	logic [CW-1:0]         coord_col, coord_row;
	logic                  map_busy;
	logic                  accept;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [COUNT_BITS-1:0] rd_data;

	logic                  v_s5;
	vfh_item_t             it_s5;
	logic [AW-1:0]         addr_s5;

	logic                  done;
	logic [COUNT_BITS-1:0] cnt, nxt, res;
	logic                  item_we;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;

	logic                  m_tvalid_q;
	logic [ECHO_W-1:0]     col_q, row_q;
	logic [OUT_CNT_W-1:0]  count_q;
	logic                  last_q;

	assign accept   = s_tvalid & s_tready;
	assign done     = v_s5 & (~m_tvalid_q | m_tready);
	assign s_tready = ~clr_q & (~(map_busy | v_s5) | done);

	vfh_bin_map #(
		.SIDE(SIDE)
	) u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (s_tdata[1:0]),
		.vec_u        (s_tdata[17:2]),
		.vec_v        (s_tdata[33:18]),
		.read_col     (s_tdata[39:34]),
		.read_row     (s_tdata[45:40]),
		.frame_end    (s_tlast),
		.bins_per_unit(bpu_q),
		.grid_side    (gside_q),
		.item         (item),
		.coord_col    (coord_col),
		.coord_row    (coord_row),
		.busy         (map_busy)
	);

	assign rd_en   = item.vld & item.hit;
	assign rd_addr = AW'(coord_row) * AW'(SIDE) + AW'(coord_col);

	always_comb begin
		cnt = it_s5.hit ? rd_data : '0;
		nxt = (cnt == '1) ? cnt : cnt + 1'b1;
		res = (it_s5.op == OP_ADD) ? nxt : cnt;
		item_we = done & it_s5.hit & ((it_s5.op == OP_ADD) | (it_s5.op == OP_CLEAR));
		ram_we  = clr_q | item_we;
		if (clr_q) begin
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_waddr = addr_s5;
			ram_wdata = (it_s5.op == OP_ADD) ? nxt : '0;
		end
	end

	vfh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpu_q      <= CFG_W'(1);
			gside_q    <= CFG_W'(3);
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			v_s5       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BINS_PER_UNIT: bpu_q   <= cfg_data;
					REG_GRID_SIDE:     gside_q <= cfg_data;
					default: ;
				endcase
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (item.vld) begin
				v_s5 <= 1'b1;
			end else if (done) begin
				v_s5 <= 1'b0;
			end
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.vld) begin
			it_s5   <= item;
			addr_s5 <= rd_addr;
		end
		if (done) begin
			col_q   <= it_s5.col;
			row_q   <= it_s5.row;
			count_q <= OUT_CNT_W'(res);
			last_q  <= it_s5.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, count_q, row_q, col_q};
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !clr_q) else $error("request accepted during RAM sweep");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({map_busy, v_s5})) else $error("more than one request in flight");
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> v_s5) else $error("RAM read without write-back stage");
	a_add_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && it_s5.op == OP_ADD |-> res != '0) else $error("add returned zero count");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !it_s5.hit |-> res == '0 && !item_we) else $error("out-of-grid read touched RAM");
`endif

endmodule

/* rtl/core/vfh_ram.sv */
module vfh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/vfh_bin_map.sv */
module vfh_bin_map
	import vfh_pkg::*;
#(
	parameter int SIDE = SIDE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [1:0]                op,
	input  logic signed [15:0]        vec_u,
	input  logic signed [15:0]        vec_v,
	input  logic [ECHO_W-1:0]         read_col,
	input  logic [ECHO_W-1:0]         read_row,
	input  logic                      frame_end,
	input  logic [CFG_W-1:0]          bins_per_unit,
	input  logic [CFG_W-1:0]          grid_side,
	output vfh_item_t                 item,
	output logic [$clog2(SIDE)-1:0]   coord_col,
	output logic [$clog2(SIDE)-1:0]   coord_row,
	output logic                      busy
);

	localparam int CW = $clog2(SIDE);
	localparam int SW = $clog2(SIDE + 1);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [1:0]        op_s1, op_s2, op_s3;
	logic              last_s1, last_s2, last_s3;
	logic [ECHO_W-1:0] rcol_s1, rcol_s2, rcol_s3;
	logic [ECHO_W-1:0] rrow_s1, rrow_s2, rrow_s3;
	logic signed [15:0] u_s1, v_in_s1;
	logic signed [23:0] prod_u_s2, prod_v_s2;
	logic              neg_u_s3, neg_v_s3;
	logic [15:0]       r_u_s3, r_v_s3;

	logic [SW-1:0]     side_eff;
	logic [SW-1:0]     half;
	logic signed [17:0] lim;
	logic [23:0]       mag_u, mag_v, rnd_u, rnd_v;
	logic [CW-1:0]     pos_u, pos_v;
	logic              in_grid;

	vfh_item_t         item_s4;
	logic [CW-1:0]     col_s4, row_s4;

	function automatic logic [CW-1:0] place(input logic [15:0] r, input logic neg,
		input logic [SW-1:0] h, input logic signed [17:0] top);
		logic signed [17:0] p;
		logic signed [17:0] rs;
		logic [CW-1:0]      res;
		rs = 18'(r);
		p  = 18'(h) + (neg ? -rs : rs);
		if (p < 0) begin
			res = '0;
		end else if (p > top) begin
			res = CW'(top);
		end else begin
			res = CW'(p);
		end
		return res;
	endfunction

	always_comb begin
		if (grid_side == '0) begin
			side_eff = SW'(1);
		end else if ({25'd0, grid_side} > 32'(SIDE)) begin
			side_eff = SW'(SIDE);
		end else begin
			side_eff = SW'(grid_side);
		end
		half = side_eff >> 1;
		lim  = 18'(side_eff) - 18'sd1;
	end

	always_comb begin
		mag_u   = prod_u_s2[23] ? -prod_u_s2 : prod_u_s2;
		mag_v   = prod_v_s2[23] ? -prod_v_s2 : prod_v_s2;
		rnd_u   = mag_u + 24'd128;
		rnd_v   = mag_v + 24'd128;
		pos_u   = place(r_u_s3, neg_u_s3, half, lim);
		pos_v   = place(r_v_s3, neg_v_s3, half, lim);
		in_grid = ({26'd0, rcol_s3} < 32'(side_eff)) && ({26'd0, rrow_s3} < 32'(side_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			u_s1    <= vec_u;
			v_in_s1 <= vec_v;
			rcol_s1 <= read_col;
			rrow_s1 <= read_row;
			last_s1 <= frame_end;
		end
		prod_u_s2 <= u_s1 * $signed({1'b0, bins_per_unit});
		prod_v_s2 <= v_in_s1 * $signed({1'b0, bins_per_unit});
		op_s2     <= op_s1;
		rcol_s2   <= rcol_s1;
		rrow_s2   <= rrow_s1;
		last_s2   <= last_s1;

		neg_u_s3 <= prod_u_s2[23];
		neg_v_s3 <= prod_v_s2[23];
		r_u_s3   <= rnd_u[23:8];
		r_v_s3   <= rnd_v[23:8];
		op_s3    <= op_s2;
		rcol_s3  <= rcol_s2;
		rrow_s3  <= rrow_s2;
		last_s3  <= last_s2;

		item_s4.vld  <= v_s3;
		item_s4.op   <= op_s3;
		item_s4.last <= last_s3;
		if (op_s3 == OP_ADD) begin
			item_s4.hit <= 1'b1;
			item_s4.col <= ECHO_W'(pos_u);
			item_s4.row <= ECHO_W'(pos_v);
			col_s4      <= pos_u;
			row_s4      <= pos_v;
		end else begin
			item_s4.hit <= in_grid;
			item_s4.col <= rcol_s3;
			item_s4.row <= rrow_s3;
			col_s4      <= CW'(rcol_s3);
			row_s4      <= CW'(rrow_s3);
		end
	end

	always_comb begin
		item      = item_s4;
		item.vld  = v_s4;
		coord_col = col_s4;
		coord_row = row_s4;
		busy      = v_s1 | v_s2 | v_s3 | v_s4;
	end

endmodule
